FILE: rtl/core/sapc_pkg.sv
// Shared constants, codes and types of the source-address packet counter.
`default_nettype none
package sapc_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = 32;
	localparam int CNT_W       = 32;
	localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRIES_W   = 9;
	localparam int GROUP_SIZE  = 16;
	localparam int NUM_GROUPS  = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int PAD_DEPTH   = NUM_GROUPS * GROUP_SIZE;

	typedef logic [1:0] req_t;
	localparam req_t REQ_COUNT = 2'd0;
	localparam req_t REQ_QUERY = 2'd1;
	localparam req_t REQ_CLEAR = 2'd2;
	localparam req_t REQ_RSVD  = 2'd3;

	typedef logic [2:0] status_t;
	localparam status_t ST_INCREMENTED = 3'd0;
	localparam status_t ST_INSERTED    = 3'd1;
	localparam status_t ST_FOUND       = 3'd2;
	localparam status_t ST_NOT_FOUND   = 3'd3;
	localparam status_t ST_OWN_SKIPPED = 3'd4;
	localparam status_t ST_TABLE_FULL  = 3'd5;
	localparam status_t ST_CLEARED     = 3'd6;

	typedef struct packed {
		logic [ADDR_W-1:0] key;
		logic              inc;
		logic              ins;
	} cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/core/sapc_cell.sv
// One table cell: holds an address and its count, compares against the key and shifts on insert.
`default_nettype none
module sapc_cell
	import sapc_pkg::*;
(
	input  wire logic              clk,
	input  wire cell_ctrl_t        ctrl,
	input  wire logic              occupied,
	input  wire logic              left_lt,
	input  wire logic [ADDR_W-1:0] left_addr,
	input  wire logic [CNT_W-1:0]  left_cnt,
	output logic [ADDR_W-1:0]      addr_q,
	output logic [CNT_W-1:0]       cnt_q,
	output logic                   lt_s1,
	output logic                   eq_s1,
	output logic [CNT_W-1:0]       cnt_s1
);

	logic eq;

	assign eq = occupied && (addr_q == ctrl.key);

	always_ff @(posedge clk) begin
		lt_s1  <= occupied && (addr_q < ctrl.key);
		eq_s1  <= eq;
		cnt_s1 <= eq ? cnt_q : '0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.inc && eq_s1) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (ctrl.ins && !lt_s1) begin
			if (left_lt) begin
				addr_q <= ctrl.key;
				cnt_q  <= CNT_W'(1);
			end else begin
				addr_q <= left_addr;
				cnt_q  <= left_cnt;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/sapc_group.sv
// Registered reduction of the match flags and matched counts of one group of cells.
`default_nettype none
module sapc_group
	import sapc_pkg::*;
(
	input  wire logic                                clk,
	input  wire logic [GROUP_SIZE-1:0]               eq,
	input  wire logic [GROUP_SIZE-1:0][CNT_W-1:0]    cnt,
	output logic                                     hit_s2,
	output logic [CNT_W-1:0]                         cnt_s2
);

	logic [CNT_W-1:0] cnt_or;

	always_comb begin
		cnt_or = '0;
		for (int k = 0; k < GROUP_SIZE; k++) begin
			cnt_or = cnt_or | cnt[k];
		end
	end

	always_ff @(posedge clk) begin
		hit_s2 <= |eq;
		cnt_s2 <= cnt_or;
	end

endmodule
`default_nettype wire

FILE: rtl/core/source_address_packet_counter_core.sv
// Top level of the source-address packet counter: a sorted chain of address cells.
// Each request passes through these steps: accept, compare in every cell, group reduction,
// then the commit that updates the cells and loads the result register.
// One request is in progress at a time, so a new request is taken only once the last one has
// committed, which needs the result register free; a stalled result holds the commit cycle.
// Reset empties the table and clears own_q; cell contents are not reset.
`default_nettype none
module source_address_packet_counter_core
	import sapc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [ADDR_W-1:0]     cfg_wr_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            req_type,
	input  wire logic [ADDR_W-1:0]     src_addr,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [2:0]                 status,
	output logic [CNT_W-1:0]           count,
	output logic [ENTRIES_W-1:0]       entries_used
);

	typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_GRP, ST_FIN} state_t;

	state_t                state_q;
	logic [ADDR_W-1:0]     own_q;
	logic [ADDR_W-1:0]     key_q;
	req_t                  req_q;
	logic [USED_W-1:0]     used_q;
	logic                  out_valid_q;
	status_t               status_q;
	logic [CNT_W-1:0]      count_q;
	logic [ENTRIES_W-1:0]  entries_q;

	cell_ctrl_t            cell_ctrl;
	logic [ADDR_W-1:0]     cell_addr [TABLE_DEPTH];
	logic [CNT_W-1:0]      cell_cnt [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] lt_s1;
	logic [TABLE_DEPTH-1:0] eq_s1;
	logic [CNT_W-1:0]      cnt_s1 [TABLE_DEPTH];
	logic [ADDR_W-1:0]     left_addr [TABLE_DEPTH];
	logic [CNT_W-1:0]      left_cnt [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] left_lt;

	logic [PAD_DEPTH-1:0]             eq_pad;
	logic [PAD_DEPTH-1:0][CNT_W-1:0]  cnt_pad;
	logic [NUM_GROUPS-1:0]            grp_hit_s2;
	logic [NUM_GROUPS-1:0][CNT_W-1:0] grp_cnt_s2;

	logic                  hit;
	logic [CNT_W-1:0]      hit_cnt;
	logic                  fire;
	logic                  do_inc;
	logic                  do_ins;
	status_t               nxt_status;
	logic [CNT_W-1:0]      nxt_count;
	logic [USED_W-1:0]     nxt_used;

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign count        = count_q;
	assign entries_used = entries_q;

	assign cell_ctrl.key = key_q;
	assign cell_ctrl.inc = fire && do_inc;
	assign cell_ctrl.ins = fire && do_ins;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_lt[i]   = 1'b1;
			assign left_addr[i] = key_q;
			assign left_cnt[i]  = CNT_W'(1);
		end else begin : g_body
			assign left_lt[i]   = lt_s1[i-1];
			assign left_addr[i] = cell_addr[i-1];
			assign left_cnt[i]  = cell_cnt[i-1];
		end

		sapc_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl),
			.occupied  (used_q > USED_W'(i)),
			.left_lt   (left_lt[i]),
			.left_addr (left_addr[i]),
			.left_cnt  (left_cnt[i]),
			.addr_q    (cell_addr[i]),
			.cnt_q     (cell_cnt[i]),
			.lt_s1     (lt_s1[i]),
			.eq_s1     (eq_s1[i]),
			.cnt_s1    (cnt_s1[i])
		);
	end

	for (genvar j = 0; j < PAD_DEPTH; j++) begin : g_pad
		if (j < TABLE_DEPTH) begin : g_real
			assign eq_pad[j]  = eq_s1[j];
			assign cnt_pad[j] = cnt_s1[j];
		end else begin : g_fill
			assign eq_pad[j]  = 1'b0;
			assign cnt_pad[j] = '0;
		end
	end

	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
		sapc_group u_group (
			.clk    (clk),
			.eq     (eq_pad[g*GROUP_SIZE +: GROUP_SIZE]),
			.cnt    (cnt_pad[g*GROUP_SIZE +: GROUP_SIZE]),
			.hit_s2 (grp_hit_s2[g]),
			.cnt_s2 (grp_cnt_s2[g])
		);
	end

	always_comb begin
		hit_cnt = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			hit_cnt = hit_cnt | grp_cnt_s2[g];
		end
	end

	assign hit  = |grp_hit_s2;
	assign fire = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		do_inc     = 1'b0;
		do_ins     = 1'b0;
		nxt_status = ST_NOT_FOUND;
		nxt_count  = '0;
		nxt_used   = used_q;
		unique case (req_q) inside
			REQ_CLEAR: begin
				nxt_status = ST_CLEARED;
				nxt_used   = '0;
			end
			REQ_COUNT: begin
				if (key_q == own_q) begin
					nxt_status = ST_OWN_SKIPPED;
				end else if (hit) begin
					do_inc     = 1'b1;
					nxt_status = ST_INCREMENTED;
					nxt_count  = hit_cnt + CNT_W'(1);
				end else if (used_q == USED_W'(TABLE_DEPTH)) begin
					nxt_status = ST_TABLE_FULL;
				end else begin
					do_ins     = 1'b1;
					nxt_status = ST_INSERTED;
					nxt_count  = CNT_W'(1);
					nxt_used   = used_q + USED_W'(1);
				end
			end
			REQ_QUERY, REQ_RSVD: begin
				if (hit) begin
					nxt_status = ST_FOUND;
					nxt_count  = hit_cnt;
				end
			end
			default: begin
				nxt_status = ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= '0;
		end else if (cfg_wr_en) begin
			own_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			key_q <= src_addr;
			req_q <= req_type;
		end
		if (fire) begin
			status_q  <= nxt_status;
			count_q   <= nxt_count;
			entries_q <= ENTRIES_W'(nxt_used);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_GRP;
				end
				ST_GRP: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fire) begin
						state_q     <= ST_IDLE;
						used_q      <= nxt_used;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_used_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(TABLE_DEPTH))
		else $error("Occupied entry count exceeds the table depth.");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("A result appeared without a commit cycle.");

	a_accept_starts_compare: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_CMP))
		else $error("An accepted request did not enter the compare cycle.");

	a_insert_count_one: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_INSERTED) |-> (count == CNT_W'(1)))
		else $error("An inserted address reported a count other than one.");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_CLEARED) |-> (entries_used == '0))
		else $error("A cleared table reported occupied entries.");

endmodule
`default_nettype wire
